// ===== sv/assert_macros.svh =====
// Assertion macros used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that expr holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, c, r, expr) \
  lbl: assert property (@(posedge c) disable iff (!(r)) (expr)) \
    else $error("assertion failed: invariant");

// Checks that cons holds in the cycle after ante.
`define ASSERT_NEXT(lbl, c, r, ante, cons) \
  lbl: assert property (@(posedge c) disable iff (!(r)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== sv/drc_pkg.sv =====
// Package: constants and action codes of the dirty rectangle coalescer.
package drc_pkg;

  localparam int TABLE_DEPTH_DEF = 32;
  localparam int COORD_BITS_DEF  = 16;

  localparam int          OVH_W     = 16;
  localparam logic [15:0] OVH_RESET = 16'd25;

  localparam int ACT_W   = 2;
  localparam int IDX_IN_W = 5;
  localparam int CNT_OUT_W = 6;

  typedef enum logic [ACT_W-1:0] {
    ACT_ADD   = 2'd0,
    ACT_READ  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

endpackage

// ===== sv/dirty_rect_coalescer_top.sv =====
// Top level: dirty rectangle table with coalescing insert, read and clear.
//
// The table lives in one synchronous RAM split into two banks of TABLE_DEPTH
// entries (rounded up to a power of two); an add streams the current bank from
// head to tail and writes the kept entries plus the merged rectangle into the
// other bank, then swaps banks.
// An add walks the table entry by entry: S_MUL forms the bounding box and its
// area product, S_CMP compares and updates the merged rectangle that the next
// entry depends on. A read goes through the RAM read (S_RDW), then the result
// (S_RESP); a clear or an unused action goes straight to the result. Results sit
// in an output register, so an item is accepted while the previous result still
// waits. No clearing pass after reset.
`include "assert_macros.svh"

module dirty_rect_coalescer_top #(
  parameter int TABLE_DEPTH = drc_pkg::TABLE_DEPTH_DEF,
  parameter int COORD_BITS  = drc_pkg::COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,

  input  logic                              cfg_wr_en,
  input  logic [drc_pkg::OVH_W-1:0]         cfg_wr_data,

  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [drc_pkg::ACT_W-1:0]         in_action,
  input  logic signed [COORD_BITS-1:0]      in_new_x1,
  input  logic signed [COORD_BITS-1:0]      in_new_y1,
  input  logic signed [COORD_BITS-1:0]      in_new_x2,
  input  logic signed [COORD_BITS-1:0]      in_new_y2,
  input  logic [drc_pkg::IDX_IN_W-1:0]      in_read_index,

  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [drc_pkg::CNT_OUT_W-1:0]     out_entry_count,
  output logic                              out_forced_merge,
  output logic                              out_entry_valid,
  output logic signed [COORD_BITS-1:0]      out_x1,
  output logic signed [COORD_BITS-1:0]      out_y1,
  output logic signed [COORD_BITS-1:0]      out_x2,
  output logic signed [COORD_BITS-1:0]      out_y2
);

  localparam int CW     = COORD_BITS;
  localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int ADDR_W = IDX_W + 1;
  localparam int MEM_D  = 1 << ADDR_W;
  localparam int ENT_W  = 4 * CW;
  localparam int PW     = 2 * CW + 2;
  localparam int SW     = PW + 2;
  localparam logic [CNT_W-1:0] FULL_KEPT = CNT_W'(TABLE_DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE, S_INIT, S_MUL, S_CMP, S_FINAL, S_RDW, S_RESP
  } state_t;

  function automatic logic signed [PW-1:0] area(
    input logic signed [CW-1:0] x1, input logic signed [CW-1:0] y1,
    input logic signed [CW-1:0] x2, input logic signed [CW-1:0] y2);
    logic signed [CW:0] dx;
    logic signed [CW:0] dy;
    dx = (CW+1)'(x2) - (CW+1)'(x1);
    dy = (CW+1)'(y2) - (CW+1)'(y1);
    return PW'(dx) * PW'(dy);
  endfunction

  // logical position -> physical slot: kept entries are stored in visit order
  function automatic logic [IDX_W-1:0] phys(
    input logic [CNT_W-1:0] pos, input logic [CNT_W-1:0] cnt);
    logic [CNT_W-1:0] p;
    if (CNT_W'(pos + 1'b1) < cnt) begin
      p = cnt - pos - CNT_W'(2);
    end else begin
      p = pos;
    end
    return p[IDX_W-1:0];
  endfunction

  // table RAM
  logic [ENT_W-1:0]  mem [MEM_D];
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [ENT_W-1:0]  rd_q;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [ENT_W-1:0]  wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  state_t                  state_r;
  logic                    bank_r;
  logic [CNT_W-1:0]        count_r;
  logic [CNT_W-1:0]        pos_r;
  logic [CNT_W-1:0]        kept_r;
  logic                    forced_r;
  logic [drc_pkg::OVH_W-1:0] ovh_r;

  logic signed [CW-1:0]    ax1_r, ay1_r, ax2_r, ay2_r;
  logic signed [CW-1:0]    bx1_r, by1_r, bx2_r, by2_r;
  logic [ENT_W-1:0]        ent_r;
  logic signed [PW-1:0]    area_a_r, area_e_r, area_b_r;
  logic                    rd_ok_r;

  logic [CNT_W-1:0]        res_count_r;
  logic                    res_forced_r;
  logic                    res_valid_r;
  logic signed [CW-1:0]    res_x1_r, res_y1_r, res_x2_r, res_y2_r;

  logic                    out_valid_r;
  logic [CNT_W-1:0]        out_count_r;
  logic                    out_forced_r;
  logic                    out_ev_r;
  logic signed [CW-1:0]    out_x1_r, out_y1_r, out_x2_r, out_y2_r;

  logic                    in_acc;
  logic                    out_free;
  logic                    rd_idx_ok;
  logic [CNT_W-1:0]        rd_idx;
  logic signed [CW-1:0]    ex1, ey1, ex2, ey2;
  logic signed [CW-1:0]    bx1, by1, bx2, by2;
  logic signed [SW-1:0]    lhs;
  logic                    keep_raw;
  logic                    force_now;
  logic                    keep;
  logic [CNT_W-1:0]        pos_inc;
  logic [31:0]             cnt_ext;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign rd_idx_ok = 32'(in_read_index) < 32'(count_r);
  assign rd_idx    = CNT_W'(in_read_index);
  assign pos_inc   = pos_r + 1'b1;

  assign ex1 = $signed(rd_q[4*CW-1 -: CW]);
  assign ey1 = $signed(rd_q[3*CW-1 -: CW]);
  assign ex2 = $signed(rd_q[2*CW-1 -: CW]);
  assign ey2 = $signed(rd_q[CW-1 -: CW]);

  assign bx1 = (ax1_r < ex1) ? ax1_r : ex1;
  assign by1 = (ay1_r < ey1) ? ay1_r : ey1;
  assign bx2 = (ax2_r > ex2) ? ax2_r : ex2;
  assign by2 = (ay2_r > ey2) ? ay2_r : ey2;

  // a1 + a2 + overhead < a3, with the overhead added once on the left side
  assign lhs       = SW'(area_a_r) + SW'(area_e_r) + SW'($signed({1'b0, ovh_r}));
  assign keep_raw  = lhs < SW'(area_b_r);
  assign force_now = keep_raw && (kept_r >= FULL_KEPT);
  assign keep      = keep_raw && !force_now;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = {bank_r, phys(pos_r, count_r)};
    wr_en   = 1'b0;
    wr_addr = {~bank_r, kept_r[IDX_W-1:0]};
    wr_data = ent_r;
    unique case (state_r)
      S_IDLE: begin
        rd_en   = in_acc && (in_action == drc_pkg::ACT_READ) && rd_idx_ok;
        rd_addr = {bank_r, phys(rd_idx, count_r)};
      end
      S_INIT: begin
        rd_en = (count_r != '0);
      end
      S_MUL: begin
        rd_en   = (pos_inc < count_r);
        rd_addr = {bank_r, phys(pos_inc, count_r)};
      end
      S_CMP: begin
        wr_en = keep;
      end
      S_FINAL: begin
        wr_en   = 1'b1;
        wr_data = {ax1_r, ay1_r, ax2_r, ay2_r};
      end
      S_RDW, S_RESP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      bank_r      <= 1'b0;
      count_r     <= '0;
      ovh_r       <= drc_pkg::OVH_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        ovh_r <= cfg_wr_data;
      end
      if (state_r == S_RESP && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            res_forced_r <= 1'b0;
            res_valid_r  <= 1'b0;
            res_x1_r     <= '0;
            res_y1_r     <= '0;
            res_x2_r     <= '0;
            res_y2_r     <= '0;
            res_count_r  <= (in_action == drc_pkg::ACT_CLEAR) ? '0 : count_r;
            unique case (drc_pkg::action_t'(in_action))
              drc_pkg::ACT_ADD: begin
                ax1_r    <= in_new_x1;
                ay1_r    <= in_new_y1;
                ax2_r    <= in_new_x2;
                ay2_r    <= in_new_y2;
                pos_r    <= '0;
                kept_r   <= '0;
                forced_r <= 1'b0;
                state_r  <= S_INIT;
              end
              drc_pkg::ACT_READ: begin
                rd_ok_r <= rd_idx_ok;
                state_r <= S_RDW;
              end
              drc_pkg::ACT_CLEAR: begin
                count_r <= '0;
                state_r <= S_RESP;
              end
              drc_pkg::ACT_NONE: begin
                state_r <= S_RESP;
              end
              default: begin
                state_r <= S_RESP;
              end
            endcase
          end
        end
        S_INIT: begin
          area_a_r <= area(ax1_r, ay1_r, ax2_r, ay2_r);
          state_r  <= (count_r != '0) ? S_MUL : S_FINAL;
        end
        S_MUL: begin
          ent_r    <= rd_q;
          bx1_r    <= bx1;
          by1_r    <= by1;
          bx2_r    <= bx2;
          by2_r    <= by2;
          area_e_r <= area(ex1, ey1, ex2, ey2);
          area_b_r <= area(bx1, by1, bx2, by2);
          state_r  <= S_CMP;
        end
        S_CMP: begin
          if (keep) begin
            kept_r <= kept_r + 1'b1;
          end else begin
            ax1_r    <= bx1_r;
            ay1_r    <= by1_r;
            ax2_r    <= bx2_r;
            ay2_r    <= by2_r;
            area_a_r <= area_b_r;
          end
          if (force_now) begin
            forced_r <= 1'b1;
          end
          pos_r   <= pos_inc;
          state_r <= (pos_inc < count_r) ? S_MUL : S_FINAL;
        end
        S_FINAL: begin
          count_r      <= kept_r + 1'b1;
          bank_r       <= ~bank_r;
          res_count_r  <= kept_r + 1'b1;
          res_forced_r <= forced_r;
          state_r      <= S_RESP;
        end
        S_RDW: begin
          if (rd_ok_r) begin
            res_valid_r <= 1'b1;
            res_x1_r    <= ex1;
            res_y1_r    <= ey1;
            res_x2_r    <= ex2;
            res_y2_r    <= ey2;
          end
          state_r <= S_RESP;
        end
        S_RESP: begin
          if (out_free) begin
            out_count_r  <= res_count_r;
            out_forced_r <= res_forced_r;
            out_ev_r     <= res_valid_r;
            out_x1_r     <= res_x1_r;
            out_y1_r     <= res_y1_r;
            out_x2_r     <= res_x2_r;
            out_y2_r     <= res_y2_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign cnt_ext          = 32'(out_count_r);
  assign out_valid        = out_valid_r;
  assign out_entry_count  = cnt_ext[drc_pkg::CNT_OUT_W-1:0];
  assign out_forced_merge = out_forced_r;
  assign out_entry_valid  = out_ev_r;
  assign out_x1           = out_x1_r;
  assign out_y1           = out_y1_r;
  assign out_x2           = out_x2_r;
  assign out_y2           = out_y2_r;

  `ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_r <= DEPTH_CNT)
  `ASSERT_ALWAYS(a_kept_bound, clk, rst_n,
                 !(state_r == S_CMP || state_r == S_FINAL) || kept_r < DEPTH_CNT)
  `ASSERT_NEXT(a_add_nonempty, clk, rst_n, state_r == S_FINAL, count_r != '0)
  `ASSERT_NEXT(a_bank_swap_only_final, clk, rst_n, state_r != S_FINAL, $stable(bank_r))

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the dirty rectangle coalescer: predicts every result beat.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import drc_pkg::*;

  localparam int STALL_LIMIT = 5000;

  typedef logic signed [COORD_BITS_DEF-1:0] coord_t;

  typedef struct {
    coord_t x1, y1, x2, y2;
  } rect_t;

  typedef struct packed {
    logic [CNT_OUT_W-1:0] entry_count;
    logic                 forced;
    logic                 valid;
    coord_t               x1, y1, x2, y2;
  } result_t;

  class rect_table_tracker;
    rect_t            entries[TABLE_DEPTH_DEF];
    int               count;
    logic [OVH_W-1:0] overhead;
    result_t          expected_replies[$];
    int errors, n_checked, n_add, n_forced, n_read, n_read_hit, n_clear, n_unused;

    function new();
      count = 0;
      overhead = OVH_RESET;
      errors = 0;
      n_checked = 0;
      n_add = 0;
      n_forced = 0;
      n_read = 0;
      n_read_hit = 0;
      n_clear = 0;
      n_unused = 0;
    endfunction

    function longint area_of(rect_t r);
      return (longint'(r.x2) - longint'(r.x1)) * (longint'(r.y2) - longint'(r.y1));
    endfunction

    function int pending();
      return expected_replies.size();
    endfunction

    // coalescing walk: keep an entry only when the bounding box costs more
    function void note_beat(action_t act, rect_t r, logic [IDX_IN_W-1:0] idx);
      result_t reply;
      rect_t   grow, ent, bb;
      rect_t   kept[$];
      longint  ovh;
      int      i;
      reply = '0;
      ovh = longint'(overhead);
      case (act)
        ACT_ADD: begin
          n_add++;
          grow = r;
          for (i = 0; i < count; i++) begin
            ent = entries[i];
            bb.x1 = (grow.x1 < ent.x1) ? grow.x1 : ent.x1;
            bb.y1 = (grow.y1 < ent.y1) ? grow.y1 : ent.y1;
            bb.x2 = (grow.x2 > ent.x2) ? grow.x2 : ent.x2;
            bb.y2 = (grow.y2 > ent.y2) ? grow.y2 : ent.y2;
            if (area_of(grow) + area_of(ent) + ovh < area_of(bb)) begin
              if (kept.size() < TABLE_DEPTH_DEF - 1) begin
                kept.push_back(ent);
              end else begin
                reply.forced = 1'b1;
                grow = bb;
              end
            end else begin
              grow = bb;
            end
          end
          for (i = 0; i < kept.size(); i++) entries[i] = kept[kept.size() - 1 - i];
          entries[kept.size()] = grow;
          count = kept.size() + 1;
          if (reply.forced) n_forced++;
        end
        ACT_READ: begin
          n_read++;
          if (idx < count) begin
            n_read_hit++;
            reply.valid = 1'b1;
            reply.x1 = entries[idx].x1;
            reply.y1 = entries[idx].y1;
            reply.x2 = entries[idx].x2;
            reply.y2 = entries[idx].y2;
          end
        end
        ACT_CLEAR: begin
          n_clear++;
          count = 0;
        end
        default: n_unused++;
      endcase
      reply.entry_count = CNT_OUT_W'(count);
      expected_replies.push_back(reply);
    endfunction

    function void cmp(string field, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        errors++;
        if (errors <= 40)
          $display("%0t: %s expected %h actual %h", $time, field, want, got);
      end
    endfunction

    function void check_beat(result_t got);
      result_t want;
      if (expected_replies.size() == 0) begin
        errors++;
        if (errors <= 40)
          $display("%0t: result beat with none expected, expected none actual %h", $time, got);
        return;
      end
      want = expected_replies.pop_front();
      n_checked++;
      cmp("entry_count", 16'(want.entry_count), 16'(got.entry_count));
      cmp("forced_merge", 16'(want.forced), 16'(got.forced));
      cmp("entry_valid", 16'(want.valid), 16'(got.valid));
      cmp("x1", want.x1, got.x1);
      cmp("y1", want.y1, got.y1);
      cmp("x2", want.x2, got.x2);
      cmp("y2", want.y2, got.y2);
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_wr_en;
  logic [OVH_W-1:0]       cfg_wr_data;
  logic                   in_valid;
  logic                   in_stall;
  logic [ACT_W-1:0]       in_action;
  coord_t                 in_new_x1, in_new_y1, in_new_x2, in_new_y2;
  logic [IDX_IN_W-1:0]    in_read_index;
  logic                   out_valid;
  logic                   out_stall;
  logic [CNT_OUT_W-1:0]   out_entry_count;
  logic                   out_forced_merge;
  logic                   out_entry_valid;
  coord_t                 out_x1, out_y1, out_x2, out_y2;

  rect_table_tracker sb;
  int send_idle, recv_idle, idle_cycles;
  int diag_x0, diag_y0, diag_step, diag_dir;

  dirty_rect_coalescer_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_new_x1        (in_new_x1),
    .in_new_y1        (in_new_y1),
    .in_new_x2        (in_new_x2),
    .in_new_y2        (in_new_y2),
    .in_read_index    (in_read_index),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_entry_count  (out_entry_count),
    .out_forced_merge (out_forced_merge),
    .out_entry_valid  (out_entry_valid),
    .out_x1           (out_x1),
    .out_y1           (out_y1),
    .out_x2           (out_x2),
    .out_y2           (out_y2)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic rect_t mk(int x1, int y1, int x2, int y2);
    rect_t r;
    r.x1 = coord_t'(x1);
    r.y1 = coord_t'(y1);
    r.x2 = coord_t'(x2);
    r.y2 = coord_t'(y2);
    return r;
  endfunction

  task automatic push_beat(action_t act, rect_t r, int idx);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_action     <= act;
    in_new_x1     <= r.x1;
    in_new_y1     <= r.y1;
    in_new_x2     <= r.x2;
    in_new_y2     <= r.y2;
    in_read_index <= IDX_IN_W'(idx);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_beat(act, r, IDX_IN_W'(idx));
  endtask

  task automatic write_overhead(logic [OVH_W-1:0] value);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.overhead = value;
  endtask

  // small rectangles on a diagonal grid, far enough apart to stay separate
  function automatic void pick_grid();
    diag_step = $urandom_range(300, 900);
    diag_dir  = $urandom_range(0, 1) ? 1 : -1;
    diag_x0   = -32000 + $urandom_range(0, 2000);
    diag_y0   = (diag_dir > 0) ? -32000 + $urandom_range(0, 2000)
                               : 31000 - $urandom_range(0, 2000);
  endfunction

  task automatic random_beat();
    int pick, k, w, h, x, y, idx;
    rect_t r;
    action_t act;
    pick = $urandom_range(0, 99);
    idx  = $urandom_range(0, 31);
    r.x1 = coord_t'($urandom());
    r.y1 = coord_t'($urandom());
    r.x2 = coord_t'($urandom());
    r.y2 = coord_t'($urandom());
    act  = ACT_ADD;
    if (pick < 1) begin
      act = ACT_CLEAR;
      pick_grid();
    end else if (pick < 22) begin
      act = ACT_READ;
      if (sb.count > 0 && $urandom_range(0, 3) != 0) idx = $urandom_range(0, sb.count - 1);
    end else if (pick < 25) begin
      act = action_t'($urandom_range(0, 3));
    end else if (pick < 28) begin
      act = ACT_ADD;
    end else if (pick < 78) begin
      k = $urandom_range(0, 63);
      x = diag_x0 + k * diag_step;
      y = diag_y0 + diag_dir * k * diag_step;
      r = mk(x, y, x + $urandom_range(1, 4), y + $urandom_range(1, 4));
    end else begin
      x = $urandom_range(0, 600) - 300;
      y = $urandom_range(0, 600) - 300;
      w = $urandom_range(0, 80) - 10;
      h = $urandom_range(0, 80) - 10;
      r = mk(x, y, x + w, y + h);
    end
    push_beat(act, r, idx);
  endtask

  task automatic directed_beats();
    push_beat(ACT_READ,  mk(0, 0, 0, 0), 0);
    push_beat(ACT_NONE,  mk(-1, -1, -1, -1), 31);
    push_beat(ACT_ADD,   mk(-32768, -32768, 32767, 32767), 0);
    push_beat(ACT_READ,  mk(0, 0, 0, 0), 0);
    push_beat(ACT_ADD,   mk(32767, 32767, -32768, -32768), 31);
    push_beat(ACT_READ,  mk(0, 0, 0, 0), 0);
    push_beat(ACT_ADD,   mk(100, 0, -100, 50), 0);
    push_beat(ACT_READ,  mk(0, 0, 0, 0), 0);
    push_beat(ACT_READ,  mk(0, 0, 0, 0), 1);
    push_beat(ACT_READ,  mk(0, 0, 0, 0), 31);
    push_beat(ACT_CLEAR, mk(0, 0, 0, 0), 0);
    push_beat(ACT_READ,  mk(0, 0, 0, 0), 0);
    push_beat(ACT_ADD,   mk(0, 0, 0, 0), 0);
    push_beat(ACT_ADD,   mk(2, 2, 3, 3), 0);
    push_beat(ACT_ADD,   mk(20000, 20000, 20001, 20001), 0);
    push_beat(ACT_ADD,   mk(-20000, 20000, -19999, 20001), 0);
    push_beat(ACT_ADD,   mk(-32768, 32767, -32768, 32767), 0);
    push_beat(ACT_READ,  mk(0, 0, 0, 0), 0);
    push_beat(ACT_READ,  mk(0, 0, 0, 0), 1);
    push_beat(ACT_READ,  mk(0, 0, 0, 0), 2);
    push_beat(ACT_READ,  mk(0, 0, 0, 0), 3);
    push_beat(ACT_READ,  mk(0, 0, 0, 0), 4);
    push_beat(ACT_NONE,  mk(32767, -32768, 32767, -32768), 21);
    push_beat(ACT_CLEAR, mk(-1, -1, -1, -1), 31);
  endtask

  // result side: receiver stalls, checking and the idle counter
  initial begin
    result_t seen;
    out_stall   = 1'b0;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if (rst_n) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
        else idle_cycles++;
        if (out_valid && !out_stall) begin
          seen.entry_count = out_entry_count;
          seen.forced      = out_forced_merge;
          seen.valid       = out_entry_valid;
          seen.x1          = out_x1;
          seen.y1          = out_y1;
          seen.x2          = out_x2;
          seen.y2          = out_y2;
          sb.check_beat(seen);
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_idle);
    end
  end

  initial begin
    wait (rst_n === 1'b1);
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("dirty_rect_coalescer_top: mismatch");
    $finish;
  end

  initial begin
    int phase, n;
    sb            = new();
    rst_n         = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    in_valid      = 1'b0;
    in_action     = ACT_NONE;
    in_new_x1     = '0;
    in_new_y1     = '0;
    in_new_x2     = '0;
    in_new_y2     = '0;
    in_read_index = '0;
    send_idle     = 22;
    recv_idle     = 62;
    pick_grid();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    directed_beats();

    for (phase = 0; phase < 6; phase++) begin
      send_idle = (phase < 2) ? 22 : (phase < 4) ? 62 : 0;
      recv_idle = (phase < 2) ? 62 : (phase < 4) ? 22 : 0;
      case (phase)
        0:       write_overhead(16'd0);
        1:       write_overhead(16'hFFFF);
        3:       write_overhead(OVH_RESET);
        5:       write_overhead(OVH_W'($urandom_range(1, 200)));
        default: write_overhead(OVH_W'($urandom()));
      endcase
      pick_grid();
      for (n = 0; n < 330; n++) random_beat();
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d adds (%0d with forced merge), %0d reads (%0d in range), %0d clears, %0d unused",
             sb.n_add, sb.n_forced, sb.n_read, sb.n_read_hit, sb.n_clear, sb.n_unused);
    $display("%0d result beats checked over six overhead settings and three stall patterns",
             sb.n_checked);
    if (sb.errors == 0) begin
      $display("dirty_rect_coalescer_top: match");
    end else begin
      $display("dirty_rect_coalescer_top: mismatch");
    end
    $finish;
  end

endmodule
